@@ rtl/orlc_pkg.sv @@
package orlc_pkg;

    localparam logic [1:0] FUNC_MASKS  = 2'd0;
    localparam logic [1:0] FUNC_HEADER = 2'd1;
    localparam logic [1:0] FUNC_RECORD = 2'd2;

    localparam logic REG_RULE_COUNT = 1'b0;

    localparam int RULE_COUNT_W = 5;
    localparam int CLASS_W      = 8;
    localparam int MATCH_W      = 5;
    localparam int HDR_W        = CLASS_W + 2;

    localparam int S_TDATA_W = 208;
    localparam int M_TDATA_W = 16;

    localparam int OFS_RULE_INDEX = 0;
    localparam int OFS_WORD_INDEX = 4;
    localparam int OFS_CARE       = 6;
    localparam int OFS_VALUE      = 70;
    localparam int OFS_CLASS      = 134;
    localparam int OFS_DEFAULT    = 142;
    localparam int OFS_NEVER      = 143;
    localparam int OFS_RECORD     = 144;

    typedef struct packed {
        logic take;
        logic rec_start;
        logic read;
        logic publish;
    } cmd_t;

    typedef struct packed {
        logic rec_func;
        logic rule_last;
        logic rec_last;
        logic out_free;
    } sts_t;

endpackage

@@ rtl/orlc_ctrl.sv @@
module orlc_ctrl
    import orlc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FINISH,
        ST_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next    = state_reg;
        s_tready      = 1'b0;
        cmd           = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.take = s_tvalid;
                if (s_tvalid && sts.rec_func) begin
                    cmd.rec_start = 1'b1;
                    state_next    = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                cmd.read = 1'b1;
                if (sts.rule_last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (!sts.rec_last) begin
                    state_next = ST_IDLE;
                end else if (sts.out_free) begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/orlc_datapath.sv @@
module orlc_datapath
    import orlc_pkg::*;
#(
    parameter int MAX_RULES  = 16,
    parameter int ATTR_WORDS = 4
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [S_TDATA_W-1:0]    s_tdata,
    input  logic [1:0]              s_tuser,
    input  logic                    s_tlast,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [M_TDATA_W-1:0]    m_tdata,
    input  logic [RULE_COUNT_W-1:0] rule_count,
    input  cmd_t                    cmd,
    output sts_t                    sts
);

    localparam int RW    = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int DEPTH = MAX_RULES * ATTR_WORDS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WW    = (ATTR_WORDS > 1) ? $clog2(ATTR_WORDS) : 1;
    localparam int CW    = $clog2(ATTR_WORDS + 1);

    logic [63:0]      care_mem [DEPTH];
    logic [63:0]      value_mem [DEPTH];
    logic [HDR_W-1:0] hdr_mem [MAX_RULES];

    logic [3:0]         in_rule;
    logic [1:0]         in_word;
    logic [63:0]        in_care;
    logic [63:0]        in_value;
    logic [CLASS_W-1:0] in_class;
    logic               in_default;
    logic               in_never;
    logic [63:0]        in_record;

    assign in_rule    = s_tdata[OFS_RULE_INDEX +: 4];
    assign in_word    = s_tdata[OFS_WORD_INDEX +: 2];
    assign in_care    = s_tdata[OFS_CARE +: 64];
    assign in_value   = s_tdata[OFS_VALUE +: 64];
    assign in_class   = s_tdata[OFS_CLASS +: CLASS_W];
    assign in_default = s_tdata[OFS_DEFAULT];
    assign in_never   = s_tdata[OFS_NEVER];
    assign in_record  = s_tdata[OFS_RECORD +: 64];

    logic          rule_ok;
    logic          word_ok;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    logic [63:0]          word_reg;
    logic                 last_reg;
    logic                 in_range_reg;
    logic [WW-1:0]        wsel_reg;
    logic [CW-1:0]        wc_reg;
    logic                 overflow_reg;
    logic [RW-1:0]        r_reg;
    logic                 ev_reg;
    logic [RW-1:0]        ev_rule_reg;
    logic [63:0]          care_rd_reg;
    logic [63:0]          value_rd_reg;
    logic [HDR_W-1:0]     hdr_rd_reg;
    logic [MAX_RULES-1:0] match_reg;
    logic                 found_reg;
    logic [CLASS_W-1:0]   found_cls_reg;
    logic [RW-1:0]        found_idx_reg;
    logic [CLASS_W-1:0]   fb_cls_reg;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    assign rule_ok = 32'(in_rule) < MAX_RULES;
    assign word_ok = 32'(in_word) < ATTR_WORDS;
    assign wr_addr = AW'(32'(in_rule) * ATTR_WORDS + 32'(in_word));
    assign rd_addr = AW'(32'(r_reg) * ATTR_WORDS + 32'(wsel_reg));

    always_ff @(posedge aclk) begin
        if (cmd.take && s_tuser == FUNC_MASKS && rule_ok && word_ok) begin
            care_mem[wr_addr]  <= in_care;
            value_mem[wr_addr] <= in_value;
        end
        if (cmd.take && s_tuser == FUNC_HEADER && rule_ok) begin
            hdr_mem[RW'(in_rule)] <= {in_never, in_default, in_class};
        end
        if (cmd.read) begin
            care_rd_reg  <= care_mem[rd_addr];
            value_rd_reg <= value_mem[rd_addr];
            hdr_rd_reg   <= hdr_mem[r_reg];
        end
    end

    logic [7:0]         act_count;
    logic               mismatch;
    logic               flag_new;
    logic               qualify;
    logic               in_count;
    logic               fb_hit;
    logic [CLASS_W-1:0] hdr_cls;
    logic               hdr_def;
    logic               hdr_never;
    logic [CLASS_W-1:0] out_cls;
    logic [MATCH_W-1:0] out_idx;

    assign act_count = (8'(rule_count) > 8'(MAX_RULES)) ? 8'(MAX_RULES) : 8'(rule_count);
    assign hdr_cls   = hdr_rd_reg[CLASS_W-1:0];
    assign hdr_def   = hdr_rd_reg[CLASS_W];
    assign hdr_never = hdr_rd_reg[CLASS_W+1];
    assign mismatch  = in_range_reg && ((word_reg ^ value_rd_reg) & care_rd_reg) != 64'd0;
    assign flag_new  = match_reg[ev_rule_reg] && !mismatch;
    assign qualify   = hdr_def || (flag_new && !hdr_never);
    assign in_count  = 8'(ev_rule_reg) < act_count;
    assign fb_hit    = (8'(ev_rule_reg) + 8'd1) == act_count;

    assign out_cls = found_reg ? found_cls_reg
                   : ((act_count != 8'd0) ? fb_cls_reg : '0);
    assign out_idx = found_reg ? MATCH_W'(found_idx_reg) : MATCH_W'(MAX_RULES);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wc_reg       <= '0;
            overflow_reg <= 1'b0;
            match_reg    <= '1;
            ev_reg       <= 1'b0;
            found_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
            r_reg        <= '0;
        end else begin
            ev_reg <= cmd.read;
            if (cmd.rec_start) begin
                word_reg  <= in_record;
                last_reg  <= s_tlast;
                r_reg     <= '0;
                found_reg <= 1'b0;
                if (32'(wc_reg) < ATTR_WORDS) begin
                    in_range_reg <= 1'b1;
                    wsel_reg     <= WW'(wc_reg);
                    wc_reg       <= wc_reg + CW'(1);
                end else begin
                    in_range_reg <= 1'b0;
                    overflow_reg <= 1'b1;
                end
            end
            if (cmd.read) begin
                ev_rule_reg <= r_reg;
                r_reg       <= r_reg + RW'(1);
            end
            if (ev_reg) begin
                match_reg[ev_rule_reg] <= flag_new;
                if (in_count && qualify && !found_reg) begin
                    found_reg     <= 1'b1;
                    found_cls_reg <= hdr_cls;
                    found_idx_reg <= ev_rule_reg;
                end
                if (fb_hit) begin
                    fb_cls_reg <= hdr_cls;
                end
            end
            if (cmd.publish) begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= {2'b00, overflow_reg, out_idx, out_cls};
                match_reg    <= '1;
                wc_reg       <= '0;
                overflow_reg <= 1'b0;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign sts.rec_func  = s_tuser == FUNC_RECORD;
    assign sts.rule_last = 32'(r_reg) == MAX_RULES - 1;
    assign sts.rec_last  = last_reg;
    assign sts.out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ rtl/ordered_rule_list_classifier.sv @@
// Channel   Direction  Handshake            Payload
// s_        in         s_tvalid / s_tready  tdata rule fields and record word, tuser func,
//                                           tlast last word
// m_        out        m_tvalid / m_tready  tdata class, matched rule, too-long flag
// APB       in         psel / penable       rule_count at byte address 0
//
// A rule mask or header beat is taken and written at once.
// A record word beat holds off the next beat until all MAX_RULES rules are checked: the
// rule mask memory has one read port, so the rules are checked one per cycle.
// Reset is synchronous and active low; the rule store is not cleared and needs no sweep.
// A finished result waits in the output register while the next beat is taken; a
// record end stalls only if the previous result has not been taken yet.
module ordered_rule_list_classifier
    import orlc_pkg::*;
#(
    parameter int MAX_RULES  = 16,
    parameter int ATTR_WORDS = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // rule_index, word_index, care_bits, value_bits, class_id, default_rule,
    // never_match, record_word
    input  logic [S_TDATA_W-1:0] s_tdata,
    // func
    input  logic [1:0]           s_tuser,
    input  logic                 s_tlast,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // predicted_class, matched_rule, too_long
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic [RULE_COUNT_W-1:0] rule_count_reg;
    cmd_t                    cmd;
    sts_t                    sts;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_RULE_COUNT) ? 32'(rule_count_reg) : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rule_count_reg <= '0;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_RULE_COUNT) begin
            rule_count_reg <= pwdata[RULE_COUNT_W-1:0];
        end
    end

    orlc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    orlc_datapath #(
        .MAX_RULES  (MAX_RULES),
        .ATTR_WORDS (ATTR_WORDS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .rule_count (rule_count_reg),
        .cmd        (cmd),
        .sts        (sts)
    );

`ifndef SYNTHESIS
    a_sweep_follows_record: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rec_start |=> cmd.read)
        else $error("rule sweep did not start after a record word beat");

    a_no_take_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.read |-> !s_tready)
        else $error("input taken while rules are being checked");

    a_publish_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.publish |=> m_tvalid)
        else $error("result was not presented after publish");

    a_publish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.publish |-> (!m_tvalid || m_tready))
        else $error("result published over one not yet taken");
`endif

endmodule
